/* rtl/tsac_pkg.sv */
// Shared types, constants and command encodings for the touch sample averaging block.
package tsac_pkg;

   localparam int RAW_BITS    = 12;
   localparam int SPAN_BITS   = 10;
   localparam int DIV_W       = RAW_BITS + SPAN_BITS;
   localparam int DVS_W       = RAW_BITS;
   localparam int SAMPLES_DEF = 16;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_X_RAW_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_X_RAW_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_X_SPAN    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_RAW_MIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_RAW_MAX = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_Y_SPAN    = 3'd5;

   localparam logic [RAW_BITS-1:0]  X_RAW_MIN_RST = 12'd0;
   localparam logic [RAW_BITS-1:0]  X_RAW_MAX_RST = 12'd4095;
   localparam logic [SPAN_BITS-1:0] X_SPAN_RST    = 10'd240;
   localparam logic [RAW_BITS-1:0]  Y_RAW_MIN_RST = 12'd0;
   localparam logic [RAW_BITS-1:0]  Y_RAW_MAX_RST = 12'd4095;
   localparam logic [SPAN_BITS-1:0] Y_SPAN_RST    = 10'd320;

   typedef struct packed {
      logic [RAW_BITS-1:0] raw_x;
      logic [RAW_BITS-1:0] raw_y;
   } req_payload_type;

   typedef struct packed {
      logic [SPAN_BITS-1:0] x_pos;
      logic [SPAN_BITS-1:0] y_pos;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AVG,
      ST_MAP_LOAD,
      ST_MAP,
      ST_DONE
   } tsac_state_type;

   typedef struct packed {
      logic acc_en;    // a sample beat is accepted this cycle
      logic snap;      // last beat of a burst: capture the full sum
      logic scale;     // turn the captured sum into the burst average
      logic step;      // one restoring division step
      logic map_load;  // load the divider with the scaled offset and the raw range
      logic emit;      // move both lane results into the output register
   } tsac_cmd_type;

endpackage

/* rtl/tsac_lane.sv */
// One axis lane: sample accumulator, restoring divider and calibration multiply.
module tsac_lane
   import tsac_pkg::*;
#(
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tsac_cmd_type         cmd,
   input  logic [RAW_BITS-1:0]  raw,
   input  logic [RAW_BITS-1:0]  lo,
   input  logic [RAW_BITS-1:0]  hi,
   input  logic [SPAN_BITS-1:0] span,
   output logic [SPAN_BITS-1:0] res
);

   localparam int SUM_W     = $clog2(SAMPLES * ((1 << RAW_BITS) - 1) + 1);
   localparam int AVG_LOG   = $clog2(SAMPLES);
   localparam int AVG_SHIFT = SUM_W + AVG_LOG;
   localparam int PROD_W    = 2 * SUM_W + 1;
   // Rounded-up reciprocal; exact floor division for every sum of SUM_W bits.
   localparam longint RECIP = ((longint'(1) << AVG_SHIFT) + longint'(SAMPLES) - 1)
                              / longint'(SAMPLES);
   localparam logic [SUM_W:0] RECIP_M = (SUM_W + 1)'(RECIP);

   logic [SUM_W-1:0] acc_ff, acc_in, sum_next;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic             zero_ff, zero_in;

   logic [DVS_W:0]      trial;
   logic                fits;
   logic [DVS_W:0]      trial_sub;
   logic [PROD_W-1:0]   avg_prod;
   logic [RAW_BITS-1:0] avg;
   logic                above_lo;
   logic [RAW_BITS-1:0] offset;
   logic [DIV_W-1:0]    prod;

   assign sum_next = acc_ff + SUM_W'(raw);
   assign acc_in   = cmd.snap ? '0 : sum_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_in;
      end
   end

   // Restoring division, one quotient bit per step, dividend shifted in from the top.
   assign trial     = {rem_ff, quo_ff[DIV_W-1]};
   assign fits      = trial >= {1'b0, dvs_ff};
   assign trial_sub = trial - {1'b0, dvs_ff};

   assign avg_prod = PROD_W'(quo_ff[SUM_W-1:0]) * PROD_W'(RECIP_M);

   // After the averaging pass the quotient holds the burst average.
   assign avg      = quo_ff[RAW_BITS-1:0];
   assign above_lo = avg > lo;
   assign offset   = avg - lo;
   assign prod     = DIV_W'(offset) * DIV_W'(span);

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      zero_in = zero_ff;
      if (cmd.snap) begin
         quo_in = DIV_W'(sum_next);
         rem_in = '0;
      end else if (cmd.scale) begin
         quo_in = DIV_W'(avg_prod[AVG_SHIFT +: RAW_BITS]);
      end else if (cmd.map_load) begin
         quo_in  = prod;
         rem_in  = '0;
         dvs_in  = hi - lo;
         zero_in = (hi <= lo) || !above_lo || (span == '0);
      end else if (cmd.step) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      zero_ff <= zero_in;
   end

   always_comb begin
      if (zero_ff) begin
         res = '0;
      end else if (quo_ff >= DIV_W'(span)) begin
         res = span;
      end else begin
         res = quo_ff[SPAN_BITS-1:0];
      end
   end

endmodule

/* rtl/tsac_dp.sv */
// Datapath: calibration registers, the two axis lanes and the result output register.
module tsac_dp
   import tsac_pkg::*;
#(
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tsac_cmd_type          cmd,
   output logic                  out_free,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [RAW_BITS-1:0]  x_raw_min_ff, x_raw_max_ff, y_raw_min_ff, y_raw_max_ff;
   logic [SPAN_BITS-1:0] x_span_ff, y_span_ff;
   logic [SPAN_BITS-1:0] x_res, y_res;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_raw_min_ff <= X_RAW_MIN_RST;
         x_raw_max_ff <= X_RAW_MAX_RST;
         x_span_ff    <= X_SPAN_RST;
         y_raw_min_ff <= Y_RAW_MIN_RST;
         y_raw_max_ff <= Y_RAW_MAX_RST;
         y_span_ff    <= Y_SPAN_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_X_RAW_MIN: x_raw_min_ff <= csr_wdata[RAW_BITS-1:0];
            CSR_X_RAW_MAX: x_raw_max_ff <= csr_wdata[RAW_BITS-1:0];
            CSR_X_SPAN:    x_span_ff    <= csr_wdata[SPAN_BITS-1:0];
            CSR_Y_RAW_MIN: y_raw_min_ff <= csr_wdata[RAW_BITS-1:0];
            CSR_Y_RAW_MAX: y_raw_max_ff <= csr_wdata[RAW_BITS-1:0];
            CSR_Y_SPAN:    y_span_ff    <= csr_wdata[SPAN_BITS-1:0];
            default: ;
         endcase
      end
   end

   tsac_lane #(.SAMPLES(SAMPLES)) u_lane_x (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .raw   (req_payload.raw_x),
      .lo    (x_raw_min_ff),
      .hi    (x_raw_max_ff),
      .span  (x_span_ff),
      .res   (x_res)
   );

   tsac_lane #(.SAMPLES(SAMPLES)) u_lane_y (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .raw   (req_payload.raw_y),
      .lo    (y_raw_min_ff),
      .hi    (y_raw_max_ff),
      .span  (y_span_ff),
      .res   (y_res)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_payload_ff.x_pos <= x_res;
         rsp_payload_ff.y_pos <= y_res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

/* rtl/tsac_ctrl.sv */
// Controller: burst counter, input stall and the averaging and division sequencer.
module tsac_ctrl
   import tsac_pkg::*;
#(
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic         out_free,
   output tsac_cmd_type cmd
);

   localparam int CNT_W  = $clog2(SAMPLES);
   localparam int STEP_W = $clog2(DIV_W);

   tsac_state_type    state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              last, accept, step_done;

   assign last      = cnt_ff == CNT_W'(SAMPLES - 1);
   // The final beat of a burst waits until the controller is back in ST_IDLE.
   assign req_stall = last && (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign step_done = step_ff == STEP_W'(DIV_W - 1);

   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         cnt_in = last ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         step_ff  <= step_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd          = '0;
      cmd.acc_en   = accept;
      cmd.snap     = accept && last;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && last) begin
               state_in = ST_AVG;
               step_in  = '0;
            end
         end
         ST_AVG: begin
            cmd.scale = 1'b1;
            state_in  = ST_MAP_LOAD;
         end
         ST_MAP_LOAD: begin
            cmd.map_load = 1'b1;
            state_in     = ST_MAP;
         end
         ST_MAP: begin
            cmd.step = 1'b1;
            if (step_done) begin
               step_in  = '0;
               state_in = ST_DONE;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/touch_sample_average_calibrate.sv */
// Top level of the touch sample averaging and linear calibration block.
//
// Raw x/y converter pairs arrive on the req channel, one pair per beat. The
// block sums SAMPLES pairs, divides each sum by SAMPLES, then maps each
// average onto its screen span as (avg - raw_min) * span / (raw_max - raw_min),
// clamped to 0..span, and delivers one (x_pos, y_pos) beat on the rsp channel.
// Calibration registers are to be written through the csr port only while the
// block is idle; the user must keep to this, the block does not enforce it.
// When the last pair of a burst is taken, both axes run in parallel: the sum
// is captured, the average is formed by a reciprocal multiply, the scaled
// offset is formed and loaded, the restoring divider runs the mapping, one
// quotient bit per cycle, and the result goes into the output register once
// that is free. Samples of the next burst keep being taken meanwhile; only its
// final pair is stalled until the output register has taken the result.
// A stalled result stays in the output register; the next result waits
// behind it. Reset clears the sums, the burst count and the output valid,
// and loads the default calibration.
module touch_sample_average_calibrate
   import tsac_pkg::*;
#(
   parameter int SAMPLES = SAMPLES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_payload_type       req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_payload_type       rsp_payload,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   tsac_cmd_type cmd;
   logic         out_free;

   tsac_ctrl #(.SAMPLES(SAMPLES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_free  (out_free),
      .cmd       (cmd)
   );

   tsac_dp #(.SAMPLES(SAMPLES)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .out_free    (out_free),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

endmodule

/* rtl/tsac_check.sv */
// Port-level checker for the touch sample averaging block, bound to the top level.
module tsac_check
   import tsac_pkg::*;
#(
   parameter int SAMPLES = SAMPLES_DEF
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input rsp_payload_type       rsp_payload
);

   localparam int CNT_W = $clog2(SAMPLES);

   logic [CNT_W-1:0] cnt_ff;
   logic [1:0]       pend_ff;
   logic             req_beat, rsp_beat, burst_end;

   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid && !rsp_stall;
   assign burst_end = req_beat && (cnt_ff == CNT_W'(SAMPLES - 1));

   // Track the burst position and the bursts whose result is still owed.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pend_ff <= '0;
      end else begin
         if (req_beat) begin
            cnt_ff <= burst_end ? '0 : cnt_ff + 1'b1;
         end
         pend_ff <= pend_ff + {1'b0, burst_end} - {1'b0, rsp_beat};
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result beat changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result beat without a completed burst");

   a_stall_last: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> cnt_ff == CNT_W'(SAMPLES - 1))
      else $error("sample stalled outside the last pair of a burst");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("more than two results owed");

endmodule

bind touch_sample_average_calibrate tsac_check #(.SAMPLES(SAMPLES)) u_tsac_check (.*);
